FILE: hdl/sscl_pkg.sv
// ============================================================================
// sscl_pkg
// Shared types and constants for the slab size class lookup.
// ============================================================================
`default_nettype none

package sscl_pkg;

    localparam int REQ_W   = 32;
    localparam int ID_W    = 6;
    localparam int CHUNK_W = 21;
    localparam int GF_W    = 21;
    localparam int BASE_W  = 21;
    localparam int FRAC_W  = 16;

    localparam int MAX_CLASSES_DEF = 64;
    localparam int MAX_ITEM_BYTES  = 1048576;
    // power of two; alignment is done with a mask
    localparam int ALIGN_BYTES     = 8;

    // running size: base plus alignment carry
    localparam int S_W    = BASE_W + 1;
    localparam int PROD_W = S_W + GF_W;

    localparam logic [PROD_W-1:0] LIMIT_Q16 =
        PROD_W'(MAX_ITEM_BYTES) << FRAC_W;

    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 21;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_GROWTH_FACTOR = 2'd0,
        REG_BASE_CHUNK    = 2'd1
    } cfg_reg_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL_SIZE,
        ST_EVAL,
        ST_MUL_ALIGNED,
        ST_FINISH
    } state_t;

    function automatic logic [S_W-1:0] align_up(input logic [S_W-1:0] s);
        logic [S_W-1:0] mask;
        mask = S_W'(ALIGN_BYTES - 1);
        return (s + mask) & ~mask;
    endfunction

endpackage

`default_nettype wire

FILE: hdl/sscl_mul.sv
// ============================================================================
// sscl_mul
// Shared size-by-factor multiplier with registered product.
// ============================================================================
`default_nettype none

module sscl_mul (
    input  wire logic                          clk,
    input  wire logic                          en,
    input  wire logic [sscl_pkg::S_W-1:0]      op_size,
    input  wire logic [sscl_pkg::GF_W-1:0]     op_factor,
    output logic      [sscl_pkg::PROD_W-1:0]   product
);

    logic [sscl_pkg::PROD_W-1:0] product_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            product_reg <= sscl_pkg::PROD_W'(op_size) * sscl_pkg::PROD_W'(op_factor);
        end
    end

    assign product = product_reg;

endmodule

`default_nettype wire

FILE: hdl/slab_size_class_lookup.sv
// ============================================================================
// slab_size_class_lookup
// Maps a request size to its geometric slab class and that class's chunk size.
// ============================================================================
// Input channel: in_valid/in_ready with request_size. Output channel:
// out_valid/out_ready with class_id and class_chunk_size, one result per
// request. Config channel: cfg_valid/cfg_ready (always ready) with cfg_index
// (0 = growth factor, Q5.16; 1 = base chunk size) and cfg_data.
// Class sizes are regenerated for every request by one shared multiplier:
// each class examined goes through size x factor for the bound check,
// evaluate/align and aligned x factor for the next size; a zero request
// goes straight to the finish step. One request is worked on at a time
// and in_ready is high only while the sequencer is idle.
// The result sits in an output register; a new request is accepted while
// it waits. If the receiver stalls and a second result is ready, the
// sequencer holds it until the output register frees up.
// Reset clears the output valid and loads factor 1.25 and base size 96.
// ============================================================================
`default_nettype none

module slab_size_class_lookup #(
    parameter int MAX_CLASSES = sscl_pkg::MAX_CLASSES_DEF
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               in_valid,
    output logic                                    in_ready,
    input  wire logic [sscl_pkg::REQ_W-1:0]         request_size,
    output logic                                    out_valid,
    input  wire logic                               out_ready,
    output logic      [sscl_pkg::ID_W-1:0]          class_id,
    output logic      [sscl_pkg::CHUNK_W-1:0]       class_chunk_size,
    input  wire logic                               cfg_valid,
    output logic                                    cfg_ready,
    input  wire logic [sscl_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [sscl_pkg::CFG_DATA_W-1:0]    cfg_data
);

    localparam int CLS_W = (MAX_CLASSES > 2) ? $clog2(MAX_CLASSES) : 1;
    localparam logic [CLS_W-1:0] LAST_IDX = CLS_W'(MAX_CLASSES - 1);

    sscl_pkg::state_t state_reg, state_next;

    logic [sscl_pkg::GF_W-1:0]    factor_reg;
    logic [sscl_pkg::BASE_W-1:0]  base_reg;

    logic [sscl_pkg::REQ_W-1:0]   req_reg, req_next;
    logic [sscl_pkg::S_W-1:0]     size_reg, size_next;
    logic [sscl_pkg::S_W-1:0]     aligned_reg, aligned_next;
    logic [CLS_W-1:0]             idx_reg, idx_next;
    logic                         from_prod_reg, from_prod_next;
    logic [sscl_pkg::ID_W-1:0]    cls_reg, cls_next;
    logic [sscl_pkg::CHUNK_W-1:0] chunk_reg, chunk_next;

    logic                         out_valid_reg, out_valid_next;
    logic [sscl_pkg::ID_W-1:0]    out_id_reg, out_id_next;
    logic [sscl_pkg::CHUNK_W-1:0] out_chunk_reg, out_chunk_next;

    logic                         mul_en;
    logic [sscl_pkg::S_W-1:0]     mul_op;
    logic [sscl_pkg::PROD_W-1:0]  product;

    logic [sscl_pkg::S_W-1:0]     cur_aligned;
    logic                         in_range;
    logic                         fits;
    logic                         slot_free;

    sscl_mul u_mul (
        .clk       (clk),
        .en        (mul_en),
        .op_size   (mul_op),
        .op_factor (factor_reg),
        .product   (product)
    );

    assign cur_aligned = sscl_pkg::align_up(size_reg);
    assign in_range    = (idx_reg < LAST_IDX) && (product <= sscl_pkg::LIMIT_Q16);
    assign fits        = (req_reg <= sscl_pkg::REQ_W'(cur_aligned));
    assign slot_free   = !out_valid_reg || out_ready;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            sscl_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = (request_size == '0) ? sscl_pkg::ST_FINISH
                                                      : sscl_pkg::ST_MUL_SIZE;
                end
            end
            sscl_pkg::ST_MUL_SIZE:
                state_next = sscl_pkg::ST_EVAL;
            sscl_pkg::ST_EVAL:
                state_next = (in_range && !fits) ? sscl_pkg::ST_MUL_ALIGNED
                                                 : sscl_pkg::ST_FINISH;
            sscl_pkg::ST_MUL_ALIGNED:
                state_next = sscl_pkg::ST_MUL_SIZE;
            sscl_pkg::ST_FINISH:
            begin
                if (slot_free)
                begin
                    state_next = sscl_pkg::ST_IDLE;
                end
            end
            default:
                state_next = sscl_pkg::ST_IDLE;
        endcase
    end

    always_comb
    begin
        in_ready       = 1'b0;
        mul_en         = 1'b0;
        mul_op         = aligned_reg;
        req_next       = req_reg;
        size_next      = size_reg;
        aligned_next   = aligned_reg;
        idx_next       = idx_reg;
        from_prod_next = from_prod_reg;
        cls_next       = cls_reg;
        chunk_next     = chunk_reg;
        out_id_next    = out_id_reg;
        out_chunk_next = out_chunk_reg;
        out_valid_next = out_valid_reg && !out_ready;

        unique case (state_reg)
            sscl_pkg::ST_IDLE:
            begin
                in_ready       = 1'b1;
                req_next       = request_size;
                size_next      = sscl_pkg::S_W'(base_reg);
                idx_next       = CLS_W'(1);
                from_prod_next = 1'b0;
                cls_next       = '0;
                chunk_next     = '0;
            end
            sscl_pkg::ST_MUL_SIZE:
            begin
                mul_en    = 1'b1;
                mul_op    = from_prod_reg ? product[sscl_pkg::FRAC_W +: sscl_pkg::S_W]
                                          : size_reg;
                size_next = mul_op;
            end
            sscl_pkg::ST_EVAL:
            begin
                aligned_next = cur_aligned;
                if (in_range)
                begin
                    if (fits)
                    begin
                        cls_next   = sscl_pkg::ID_W'(idx_reg);
                        chunk_next = sscl_pkg::CHUNK_W'(cur_aligned);
                    end
                end
                else if (req_reg <= sscl_pkg::REQ_W'(sscl_pkg::MAX_ITEM_BYTES))
                begin
                    cls_next   = sscl_pkg::ID_W'(idx_reg);
                    chunk_next = sscl_pkg::CHUNK_W'(sscl_pkg::MAX_ITEM_BYTES);
                end
            end
            sscl_pkg::ST_MUL_ALIGNED:
            begin
                mul_en         = 1'b1;
                mul_op         = aligned_reg;
                idx_next       = idx_reg + CLS_W'(1);
                from_prod_next = 1'b1;
            end
            sscl_pkg::ST_FINISH:
            begin
                if (slot_free)
                begin
                    out_valid_next = 1'b1;
                    out_id_next    = cls_reg;
                    out_chunk_next = chunk_reg;
                end
            end
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= sscl_pkg::ST_IDLE;
            out_valid_reg <= 1'b0;
            factor_reg    <= sscl_pkg::GF_W'(81920);
            base_reg      <= sscl_pkg::BASE_W'(96);
            idx_reg       <= '0;
            from_prod_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            idx_reg       <= idx_next;
            from_prod_reg <= from_prod_next;
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == sscl_pkg::REG_GROWTH_FACTOR)
                begin
                    factor_reg <= cfg_data;
                end
                else if (cfg_index == sscl_pkg::REG_BASE_CHUNK)
                begin
                    base_reg <= cfg_data;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        req_reg       <= req_next;
        size_reg      <= size_next;
        aligned_reg   <= aligned_next;
        cls_reg       <= cls_next;
        chunk_reg     <= chunk_next;
        out_id_reg    <= out_id_next;
        out_chunk_reg <= out_chunk_next;
    end

    assign cfg_ready        = 1'b1;
    assign out_valid        = out_valid_reg;
    assign class_id         = out_id_reg;
    assign class_chunk_size = out_chunk_reg;

endmodule

`default_nettype wire

FILE: hdl/sscl_checker.sv
// ============================================================================
// sscl_checker
// Port-level checks for the slab size class lookup, bound to the top level.
// ============================================================================
`default_nettype none

module sscl_checker (
    input wire logic                            clk,
    input wire logic                            rst_n,
    input wire logic                            in_valid,
    input wire logic                            in_ready,
    input wire logic                            out_valid,
    input wire logic                            out_ready,
    input wire logic [sscl_pkg::ID_W-1:0]       class_id,
    input wire logic [sscl_pkg::CHUNK_W-1:0]    class_chunk_size
);

    // stalled transaction holds its payload
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(class_id)
                                     && $stable(class_chunk_size))
        else $error("output changed while stalled");

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("accepted a request while busy");

    a_class0_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && class_id == '0 |-> class_chunk_size == '0)
        else $error("class 0 with nonzero chunk size");

    a_chunk_max: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> class_chunk_size
                      <= sscl_pkg::CHUNK_W'(sscl_pkg::MAX_ITEM_BYTES))
        else $error("chunk size above item limit");

    a_reset_quiet: assert property (@(posedge clk)
        !rst_n |=> !out_valid)
        else $error("output valid during reset");

endmodule

bind slab_size_class_lookup sscl_checker u_sscl_checker (.*);

`default_nettype wire
